@@ sv/upd_pkg.sv @@
// Shared types, character codes and hex helpers for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CHAR_PCT  = 8'h25;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_UA   = 8'h41;
  localparam logic [7:0] CHAR_UF   = 8'h46;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LF   = 8'h66;
  localparam logic [7:0] CASE_MASK = 8'hdf;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_NUL = 2'd1;
  localparam logic [1:0] STATUS_BAD_ESC = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UA && c <= CHAR_UF) ||
             (c >= CHAR_LA && c <= CHAR_LF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CHAR_UA) begin
      t = (c & CASE_MASK) - CHAR_UA + HEX_TEN;
    end else begin
      t = c - CHAR_ZERO;
    end
    hex_val = t[3:0];
  endfunction

endpackage

@@ sv/url_percent_decoder.sv @@
// URL percent decoder: input register, decode logic and an output word queue.
//
//   channel | handshake           | words
//   in      | in_valid / in_stall | in_byte, end_of_string
//   out     | out_valid/out_stall | out_byte, has_byte, last, status
//
// One input word is taken per cycle unless in_stall is high; each produces
// zero to three output words. An input word waits in the input register, then
// its results enter a four-word queue whose head drives the outputs.
// The input register holds while the queue lacks room for three words.
// rst is synchronous and empties both the input register and the queue.
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       last,
  output logic [1:0] status
);

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} phase_t;

  localparam int Depth = 4;

  phase_t     phase, phase_next;
  logic [7:0] held_digit, held_digit_next;
  logic       bad_escape_seen, bad_escape_seen_next;
  logic       bad_path_seen, bad_path_seen_next;

  logic       in_full;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  res_t       slots [Depth];
  res_t       slots_next [Depth];
  logic [2:0] count, count_next;

  res_t       res [3];
  logic [1:0] nres;
  logic       pop, proc, accept, is_end;
  logic [2:0] base;
  logic [2:0] widx;
  logic [7:0] dec_val;

  assign pop      = (count != 3'd0) && !out_stall;
  assign base     = count - {2'b0, pop};
  assign proc     = in_full && (base <= 3'd1);
  assign in_stall = in_full && !proc;
  assign accept   = in_valid && !in_stall;
  assign is_end   = in_end_r || (in_byte_r == 8'd0);
  assign dec_val  = {hex_val(held_digit), hex_val(in_byte_r)};

  function automatic res_t byte_res(input logic [7:0] b);
    byte_res = '{out_byte: b, has_byte: 1'b1, last: 1'b0, status: STATUS_OK};
  endfunction

  always_comb begin
    logic flushed;
    flushed              = 1'b0;
    res[0]               = byte_res(CHAR_PCT);
    res[1]               = byte_res(held_digit);
    res[2]               = byte_res(in_byte_r);
    nres                 = 2'd0;
    phase_next           = phase;
    held_digit_next      = held_digit;
    bad_escape_seen_next = bad_escape_seen;
    bad_path_seen_next   = bad_path_seen;
    if (is_end) begin
      if (phase == PH_PCT || phase == PH_DIGIT) begin
        flushed = 1'b1;
        nres    = (phase == PH_DIGIT) ? 2'd2 : 2'd1;
      end
      res[nres] = '{out_byte: 8'd0, has_byte: 1'b0, last: 1'b1,
                    status: (bad_escape_seen || flushed) ? STATUS_BAD_ESC :
                            (bad_path_seen ? STATUS_BAD_NUL : STATUS_OK)};
      nres                 = nres + 2'd1;
      phase_next           = PH_IDLE;
      held_digit_next      = 8'd0;
      bad_escape_seen_next = 1'b0;
      bad_path_seen_next   = 1'b0;
    end else begin
      unique case (phase)
        PH_PCT, PH_DIGIT: begin
          if (is_hex(in_byte_r)) begin
            if (phase == PH_PCT) begin
              held_digit_next = in_byte_r;
              phase_next      = PH_DIGIT;
            end else begin
              res[0]          = byte_res(dec_val);
              nres            = 2'd1;
              phase_next      = PH_IDLE;
              held_digit_next = 8'd0;
              if (dec_val == 8'd0) begin
                bad_path_seen_next = 1'b1;
              end
            end
          end else begin
            bad_escape_seen_next = 1'b1;
            held_digit_next      = 8'd0;
            nres                 = (phase == PH_DIGIT) ? 2'd2 : 2'd1;
            res[nres]            = byte_res(in_byte_r);
            if (in_byte_r == CHAR_PCT) begin
              phase_next = PH_PCT;
            end else begin
              phase_next = PH_IDLE;
              nres       = nres + 2'd1;
            end
          end
        end
        default: begin
          res[0] = byte_res(in_byte_r);
          if (in_byte_r == CHAR_PCT) begin
            phase_next = PH_PCT;
          end else begin
            phase_next = PH_IDLE;
            nres       = 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      slots_next[i] = slots[i];
      if (pop && i < Depth - 1) begin
        slots_next[i] = slots[i + 1];
      end
    end
    widx       = base;
    count_next = base;
    if (proc) begin
      for (int j = 0; j < 3; j++) begin
        widx = base + 3'(j);
        if (2'(j) < nres) begin
          slots_next[widx[1:0]] = res[j];
        end
      end
      count_next = base + {1'b0, nres};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      count           <= 3'd0;
      phase           <= PH_IDLE;
      held_digit      <= 8'd0;
      bad_escape_seen <= 1'b0;
      bad_path_seen   <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        in_full <= 1'b1;
      end else if (proc) begin
        in_full <= 1'b0;
      end
      if (proc) begin
        phase           <= phase_next;
        held_digit      <= held_digit_next;
        bad_escape_seen <= bad_escape_seen_next;
        bad_path_seen   <= bad_path_seen_next;
      end
    end
    if (accept) begin
      in_byte_r <= in_byte;
      in_end_r  <= end_of_string;
    end
    slots <= slots_next;
  end

  assign out_valid = (count != 3'd0);
  assign out_byte  = slots[0].out_byte;
  assign has_byte  = slots[0].has_byte;
  assign last      = slots[0].last;
  assign status    = slots[0].status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(Depth))
    else $error("output queue count exceeds its depth");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    proc && nres != 2'd0 |=> out_valid)
    else $error("results pushed but no output word valid");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    proc && is_end |=> phase == PH_IDLE && !bad_escape_seen && !bad_path_seen)
    else $error("state not cleared after end of string");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    proc && is_end |-> res[nres - 2'd1].last)
    else $error("end of string did not produce a last word");
`endif

endmodule
